@@ src/mlb_pkg.sv @@
`timescale 1ns / 1ps
package mlb_pkg;

  localparam int NUM_PORTS_DEF     = 4;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int IDX_BITS          = 8;   // enough for up to 256 slots
  localparam int ADDR_BITS         = 48;
  localparam int AGE_BITS          = 16;
  localparam int GROUP_BIT         = 40;
  localparam logic [AGE_BITS-1:0] AGE_MAX   = 16'hFFFF;
  localparam logic [AGE_BITS-1:0] AGE_RESET = 16'd30;

  // item codes
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_LOCAL = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ADDR0  = 3'd0;
  localparam logic [2:0] REG_ADDR1  = 3'd1;
  localparam logic [2:0] REG_ADDR2  = 3'd2;
  localparam logic [2:0] REG_ADDR3  = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;
  localparam logic [2:0] REG_ECHO   = 3'd5;
  localparam logic [2:0] REG_AGE    = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic                 live;
    logic                 dhit;
    logic [1:0]           dport;
    logic                 shit;
    logic [IDX_BITS-1:0]  sidx;
    logic                 ffree;
    logic [IDX_BITS-1:0]  fidx;
    logic [IDX_BITS-1:0]  oidx;
    logic [AGE_BITS-1:0]  oage;
  } carry_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic                 is_new;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] addr;
    logic [1:0]           port;
  } wr_t;

endpackage

@@ src/mlb_if.sv @@
`timescale 1ns / 1ps
interface mlb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  port;
  logic [47:0] dest_addr;
  logic [47:0] src_addr;
  modport source (output valid, op, port, dest_addr, src_addr, input ready);
  modport sink   (input valid, op, port, dest_addr, src_addr, output ready);
endinterface

interface mlb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] tx_mask;
  logic       deliver_local;
  logic       rewrite_src;
  logic       dest_known;
  modport source (output valid, tx_mask, deliver_local, rewrite_src, dest_known,
                  input ready);
  modport sink   (input valid, tx_mask, deliver_local, rewrite_src, dest_known,
                  output ready);
endinterface

@@ src/mlb_cell.sv @@
`timescale 1ns / 1ps
module mlb_cell
  import mlb_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ADDR_BITS-1:0] dst,
  input  logic [ADDR_BITS-1:0] src,
  input  logic [AGE_BITS-1:0]  age_limit,
  input  logic                 tick,
  input  wr_t                  wr,
  input  carry_t               cin,
  output carry_t               cout
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

  logic [ADDR_BITS-1:0] addr_r;
  logic [1:0]           port_r;
  logic [AGE_BITS-1:0]  age_r;
  logic                 valid_r;
  carry_t               cout_r, cout_nxt;
  logic [AGE_BITS-1:0]  age_inc;

  // fold this entry into the passing search word
  always_comb begin
    cout_nxt = cin;
    if (!cin.dhit && valid_r && addr_r == dst) begin
      cout_nxt.dhit  = 1'b1;
      cout_nxt.dport = port_r;
    end
    if (!cin.shit && valid_r && addr_r == src) begin
      cout_nxt.shit = 1'b1;
      cout_nxt.sidx = MY_IDX;
    end
    if (!cin.ffree && !valid_r) begin
      cout_nxt.ffree = 1'b1;
      cout_nxt.fidx  = MY_IDX;
    end
    if (age_r > cin.oage) begin
      cout_nxt.oidx = MY_IDX;
      cout_nxt.oage = age_r;
    end
  end

  assign age_inc = (age_r < AGE_MAX) ? age_r + 1'b1 : age_r;

  // search word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r <= '0;
    end else begin
      cout_r <= cout_nxt;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.en && wr.idx == MY_IDX) begin
      valid_r <= 1'b1;
    end else if (tick && valid_r && age_inc > age_limit) begin
      valid_r <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX) begin
      if (wr.is_new) begin
        addr_r <= wr.addr;
      end
      port_r <= wr.port;
      age_r  <= '0;
    end else if (tick && valid_r) begin
      age_r <= age_inc;
    end
  end

  assign cout = cout_r;

endmodule

@@ src/mac_learning_bridge_table.sv @@
`timescale 1ns / 1ps
// MAC learning bridge table. Each input word (received frame, local frame or
// aging tick) yields exactly one result word. The table is a row of
// TABLE_ENTRIES cells; a search word walks down the row one cell per clock,
// collecting the destination hit, the source hit, the lowest free slot and
// the oldest slot. After acceptance a frame's search word is launched from a
// register, passes the TABLE_ENTRIES cell registers, and the row's result is
// captured as the block enters FINISH; the result word then goes to the output
// register and the next word can be taken. A tick or unused code goes straight
// to FINISH. A result held back by the output keeps the block in FINISH.
// One item is processed at a time; a new item is taken while the previous
// result still waits on the output. Valid bits clear at reset, no clearing
// pass. Registers sit on an APB port at an 8-byte stride.
module mac_learning_bridge_table
  import mlb_pkg::*;
#(
  parameter int NUM_PORTS     = NUM_PORTS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mlb_in_if.sink      in_ch,
  mlb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [3:0] PORTS_ALL = 4'((1 << NUM_PORTS) - 1);

  // configuration
  logic [ADDR_BITS-1:0] port_addr_r [4];
  logic [3:0]           enable_r, echo_r;
  logic [AGE_BITS-1:0]  age_limit_r;
  logic [2:0]           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) port_addr_r[i] <= '0;
      enable_r    <= '0;
      echo_r      <= '0;
      age_limit_r <= AGE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ADDR0:  port_addr_r[0] <= pwdata[47:0];
        REG_ADDR1:  port_addr_r[1] <= pwdata[47:0];
        REG_ADDR2:  port_addr_r[2] <= pwdata[47:0];
        REG_ADDR3:  port_addr_r[3] <= pwdata[47:0];
        REG_ENABLE: enable_r       <= pwdata[3:0];
        REG_ECHO:   echo_r         <= pwdata[3:0];
        REG_AGE:    age_limit_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ADDR0:  prdata = {16'd0, port_addr_r[0]};
      REG_ADDR1:  prdata = {16'd0, port_addr_r[1]};
      REG_ADDR2:  prdata = {16'd0, port_addr_r[2]};
      REG_ADDR3:  prdata = {16'd0, port_addr_r[3]};
      REG_ENABLE: prdata = {60'd0, enable_r};
      REG_ECHO:   prdata = {60'd0, echo_r};
      REG_AGE:    prdata = {48'd0, age_limit_r};
      default:    prdata = '0;
    endcase
  end

  // item latch and control
  state_t               state_r, state_nxt;
  logic [1:0]           op_r, port_r;
  logic [ADDR_BITS-1:0] dst_r, src_r;
  logic                 launch_r;
  carry_t               res_r;
  logic                 out_valid_r;
  logic [3:0]           tx_r;
  logic                 local_r, rewrite_r, known_r;
  logic                 in_acc, out_free, is_frame;
  carry_t               chain [TABLE_ENTRIES+1];
  wr_t                  wr;
  logic                 tick;
  logic [TABLE_ENTRIES:0] live_vec;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_frame    = (in_ch.op == OP_RX) || (in_ch.op == OP_LOCAL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = is_frame ? ST_SEARCH : ST_FINISH;
      ST_SEARCH: if (chain[TABLE_ENTRIES].live) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_acc && is_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.op;
      port_r <= in_ch.port;
      dst_r  <= in_ch.dest_addr;
      src_r  <= in_ch.src_addr;
    end
    if (state_r == ST_SEARCH && chain[TABLE_ENTRIES].live) begin
      res_r <= chain[TABLE_ENTRIES];
    end
  end

  // cell row
  always_comb begin
    chain[0]      = '0;
    chain[0].live = launch_r;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mlb_cell #(.CELL_IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .dst       (dst_r),
      .src       (src_r),
      .age_limit (age_limit_r),
      .tick      (tick),
      .wr        (wr),
      .cin       (chain[g]),
      .cout      (chain[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_live
    assign live_vec[g] = chain[g].live;
  end

  // forwarding decision
  logic [3:0] active, ingress, flood, hit_bit;
  logic       own, group, finish;

  assign finish  = (state_r == ST_FINISH) && out_free;
  assign active  = enable_r & PORTS_ALL;
  assign ingress = (32'(port_r) < NUM_PORTS) ? (4'd1 << port_r) : 4'd0;
  assign flood   = active & ~(ingress & ~echo_r);
  assign hit_bit = (32'(res_r.dport) < NUM_PORTS) ? (4'd1 << res_r.dport) : 4'd0;
  assign group   = dst_r[GROUP_BIT];

  always_comb begin
    own = 1'b0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (active[i] && port_addr_r[i] == dst_r) own = 1'b1;
    end
  end

  logic [3:0] tx_nxt;
  logic       local_nxt, rewrite_nxt, known_nxt;

  always_comb begin
    tx_nxt      = '0;
    local_nxt   = 1'b0;
    rewrite_nxt = 1'b0;
    known_nxt   = 1'b0;
    case (op_r)
      OP_RX: begin
        if (group) begin
          tx_nxt    = flood;
          local_nxt = 1'b1;
        end else if (own) begin
          local_nxt = 1'b1;
        end else if (res_r.dhit) begin
          tx_nxt    = hit_bit;
          known_nxt = 1'b1;
        end else begin
          tx_nxt = flood;
        end
      end
      OP_LOCAL: begin
        if (!group && res_r.dhit) begin
          tx_nxt      = hit_bit;
          rewrite_nxt = (res_r.dport != port_r);
          known_nxt   = 1'b1;
        end else begin
          tx_nxt      = active;
          rewrite_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // table update: learn on received frames, age on ticks
  always_comb begin
    wr        = '0;
    wr.en     = finish && (op_r == OP_RX);
    wr.is_new = !res_r.shit;
    wr.idx    = res_r.shit ? res_r.sidx : (res_r.ffree ? res_r.fidx : res_r.oidx);
    wr.addr   = src_r;
    wr.port   = port_r;
  end
  assign tick = finish && (op_r == OP_TICK);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      tx_r      <= tx_nxt;
      local_r   <= local_nxt;
      rewrite_r <= rewrite_nxt;
      known_r   <= known_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tx_mask       = tx_r;
  assign out_ch.deliver_local = local_r;
  assign out_ch.rewrite_src   = rewrite_r;
  assign out_ch.dest_known    = known_r;

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_vec) <= 1)
    else $error("more than one search word in the cell row");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (32'(wr.idx) < TABLE_ENTRIES))
    else $error("table write outside the row");

  a_no_tick_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && tick))
    else $error("learn and age in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second word taken before the first finished");

  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && chain[TABLE_ENTRIES].live) |=> state_r == ST_FINISH)
    else $error("search result dropped");

endmodule
